>>> rtl/core/ipc_pkg.sv
// shared constants, types and character helpers for the infix to prefix converter
package ipc_pkg;

	// buffer depth and derived widths
	localparam int MAX_LEN = 64;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CNT_W   = ADDR_W + 1;

	// character codes
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNBAL    = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// controller states
	typedef enum logic [3:0] {
		S_LOAD,
		S_START,
		S_SCAN_RD,
		S_SCAN_EX,
		S_DISP,
		S_CLOSE_RD,
		S_CLOSE_EX,
		S_OP_RD,
		S_OP_EX,
		S_FLUSH_RD,
		S_FLUSH_EX,
		S_EMIT_SET,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_EMIT_EMPTY
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_wr;   // store incoming char or flag overflow
		logic set_k;     // scan index from input length
		logic scan_rd;   // read input buffer at k-1, step k down
		logic cur_ld;    // capture swapped char into current register
		logic stk_rd;    // read stack top
		logic push_cur;  // push current char
		logic pop_app;   // append stack top read data, drop top
		logic drop_top;  // drop top without appending
		logic app_cur;   // append current char
		logic set_unbal; // flag unmatched closing
		logic set_j;     // emit index from answer length
		logic ans_rd;    // read answer buffer at j-1, step j down
		logic out_empty; // result item carries no char
		logic clear;     // return lengths and error to zero
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic k_zero;
		logic sp_zero;
		logic alen_zero;
		logic j_zero;
		logic cur_operand;
		logic cur_open;
		logic cur_close;
		logic top_is_open;
		logic pop_ok;
	} sts_t;

	// operator priority
	function automatic logic [1:0] prio(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		if (c == CH_CARET) p = 2'd3;
		else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
		else if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
		return p;
	endfunction

	// letters and digits
	function automatic logic is_operand(input logic [7:0] c);
		return c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z], [CH_DIG_0:CH_DIG_9]};
	endfunction

	// swap the two parenthesis kinds for the reversed scan
	function automatic logic [7:0] swap_paren(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c == CH_OPEN) r = CH_CLOSE;
		else if (c == CH_CLOSE) r = CH_OPEN;
		return r;
	endfunction

endpackage

>>> rtl/core/ipc_in_if.sv
// input channel: one infix character per item
interface ipc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       last_in;

	modport source (output valid, output in_char, output last_in, input ready);
	modport sink (input valid, input in_char, input last_in, output ready);
endinterface

>>> rtl/core/ipc_out_if.sv
// output channel: one prefix character per item
interface ipc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       last_out;
	logic [1:0] status;

	modport source (output valid, output out_char, output has_char, output last_out,
		output status, input ready);
	modport sink (input valid, input out_char, input has_char, input last_out,
		input status, output ready);
endinterface

>>> rtl/core/ipc_datapath.sv
// buffers, operator stack, counters and result payload of the converter
module ipc_datapath
	import ipc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [7:0] in_char,
	output logic [7:0] out_char,
	output logic       has_char,
	output logic       last_out,
	output logic [1:0] status
);

	logic [7:0]       in_mem  [MAX_LEN];
	logic [7:0]       stk_mem [MAX_LEN];
	logic [7:0]       ans_mem [MAX_LEN];

	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] sp_q;
	logic [CNT_W-1:0] alen_q;
	logic [CNT_W-1:0] j_q;
	logic [1:0]       err_q;

	logic [7:0]       in_rd_q;
	logic [7:0]       stk_rd_q;
	logic [7:0]       ans_rd_q;
	logic [7:0]       cur_q;

	logic             len_full;
	logic             sp_full;
	logic             alen_full;
	logic             do_app;
	logic [7:0]       app_data;
	logic [CNT_W-1:0] k_dec;
	logic [CNT_W-1:0] sp_dec;
	logic [CNT_W-1:0] j_dec;

	assign len_full  = (len_q == CNT_W'(MAX_LEN));
	assign sp_full   = (sp_q == CNT_W'(MAX_LEN));
	assign alen_full = (alen_q == CNT_W'(MAX_LEN));
	assign k_dec     = k_q - CNT_W'(1);
	assign sp_dec    = sp_q - CNT_W'(1);
	assign j_dec     = j_q - CNT_W'(1);

	// append source select
	assign do_app   = cmd.app_cur | cmd.pop_app;
	assign app_data = cmd.app_cur ? cur_q : stk_rd_q;

	// input buffer
	always_ff @(posedge clk) begin
		if (cmd.load_wr && !len_full) begin
			in_mem[len_q[ADDR_W-1:0]] <= in_char;
		end
		if (cmd.scan_rd) begin
			in_rd_q <= in_mem[k_dec[ADDR_W-1:0]];
		end
	end

	// operator stack
	always_ff @(posedge clk) begin
		if (cmd.push_cur && !sp_full) begin
			stk_mem[sp_q[ADDR_W-1:0]] <= cur_q;
		end
		if (cmd.stk_rd) begin
			stk_rd_q <= stk_mem[sp_dec[ADDR_W-1:0]];
		end
	end

	// answer buffer
	always_ff @(posedge clk) begin
		if (do_app && !alen_full) begin
			ans_mem[alen_q[ADDR_W-1:0]] <= app_data;
		end
		if (cmd.ans_rd) begin
			ans_rd_q <= ans_mem[j_dec[ADDR_W-1:0]];
		end
	end

	// current scanned char, parentheses swapped
	always_ff @(posedge clk) begin
		if (cmd.cur_ld) begin
			cur_q <= swap_paren(in_rd_q);
		end
	end

	// lengths, indexes and error code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			k_q    <= '0;
			sp_q   <= '0;
			alen_q <= '0;
			j_q    <= '0;
			err_q  <= ST_OK;
		end else if (cmd.clear) begin
			len_q  <= '0;
			k_q    <= '0;
			sp_q   <= '0;
			alen_q <= '0;
			j_q    <= '0;
			err_q  <= ST_OK;
		end else begin
			if (cmd.load_wr) begin
				if (len_full) err_q <= ST_TOO_LONG;
				else len_q <= len_q + CNT_W'(1);
			end
			if (cmd.set_unbal && err_q == ST_OK) begin
				err_q <= ST_UNBAL;
			end
			if (cmd.set_k) k_q <= len_q;
			else if (cmd.scan_rd) k_q <= k_dec;
			if (cmd.push_cur && !sp_full) sp_q <= sp_q + CNT_W'(1);
			else if (cmd.pop_app || cmd.drop_top) sp_q <= sp_dec;
			if (do_app && !alen_full) alen_q <= alen_q + CNT_W'(1);
			if (cmd.set_j) j_q <= alen_q;
			else if (cmd.ans_rd) j_q <= j_dec;
		end
	end

	// status toward the controller
	always_comb begin
		sts.k_zero      = (k_q == '0);
		sts.sp_zero     = (sp_q == '0);
		sts.alen_zero   = (alen_q == '0);
		sts.j_zero      = (j_q == '0);
		sts.cur_operand = is_operand(cur_q);
		sts.cur_open    = (cur_q == CH_OPEN);
		sts.cur_close   = (cur_q == CH_CLOSE);
		sts.top_is_open = (stk_rd_q == CH_OPEN);
		if (cur_q == CH_CARET) sts.pop_ok = (prio(cur_q) <= prio(stk_rd_q));
		else sts.pop_ok = (prio(cur_q) < prio(stk_rd_q));
	end

	// result payload
	assign out_char = cmd.out_empty ? 8'h00 : ans_rd_q;
	assign has_char = !cmd.out_empty;
	assign last_out = cmd.out_empty | sts.j_zero;
	assign status   = err_q;

endmodule

>>> rtl/core/ipc_ctrl.sv
// sequencer for load, reversed scan, stack flush and result emission
module ipc_ctrl
	import ipc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (in_last) state_d = S_START;
				end
			end
			S_START: begin
				cmd.set_k = 1'b1;
				state_d   = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (sts.k_zero) begin
					state_d = S_FLUSH_RD;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_EX;
				end
			end
			S_SCAN_EX: begin
				cmd.cur_ld = 1'b1;
				state_d    = S_DISP;
			end
			// dispatch on the kind of the current char
			S_DISP: begin
				if (sts.cur_operand) begin
					cmd.app_cur = 1'b1;
					state_d     = S_SCAN_RD;
				end else if (sts.cur_open) begin
					cmd.push_cur = 1'b1;
					state_d      = S_SCAN_RD;
				end else if (sts.cur_close) begin
					state_d = S_CLOSE_RD;
				end else begin
					state_d = S_OP_RD;
				end
			end
			// pop until the matching opening
			S_CLOSE_RD: begin
				if (sts.sp_zero) begin
					cmd.set_unbal = 1'b1;
					state_d       = S_SCAN_RD;
				end else begin
					cmd.stk_rd = 1'b1;
					state_d    = S_CLOSE_EX;
				end
			end
			S_CLOSE_EX: begin
				if (sts.top_is_open) begin
					cmd.drop_top = 1'b1;
					state_d      = S_SCAN_RD;
				end else begin
					cmd.pop_app = 1'b1;
					state_d     = S_CLOSE_RD;
				end
			end
			// pop by priority, then push the operator
			S_OP_RD: begin
				if (sts.sp_zero) begin
					cmd.push_cur = 1'b1;
					state_d      = S_SCAN_RD;
				end else begin
					cmd.stk_rd = 1'b1;
					state_d    = S_OP_EX;
				end
			end
			S_OP_EX: begin
				if (sts.pop_ok) begin
					cmd.pop_app = 1'b1;
					state_d     = S_OP_RD;
				end else begin
					cmd.push_cur = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			// empty the stack into the answer
			S_FLUSH_RD: begin
				if (sts.sp_zero) begin
					state_d = S_EMIT_SET;
				end else begin
					cmd.stk_rd = 1'b1;
					state_d    = S_FLUSH_EX;
				end
			end
			S_FLUSH_EX: begin
				cmd.pop_app = 1'b1;
				state_d     = S_FLUSH_RD;
			end
			// emit the answer backwards
			S_EMIT_SET: begin
				cmd.set_j = 1'b1;
				state_d   = sts.alen_zero ? S_EMIT_EMPTY : S_EMIT_RD;
			end
			S_EMIT_RD: begin
				cmd.ans_rd = 1'b1;
				state_d    = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.j_zero) begin
						cmd.clear = 1'b1;
						state_d   = S_LOAD;
					end else begin
						state_d = S_EMIT_RD;
					end
				end
			end
			S_EMIT_EMPTY: begin
				out_valid     = 1'b1;
				cmd.out_empty = 1'b1;
				if (out_ready) begin
					cmd.clear = 1'b1;
					state_d   = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

>>> rtl/core/infix_to_prefix_converter_unit.sv
// top level of the infix to prefix converter
// Takes an infix expression one character per item, the final one marked by
// last_in, and returns its prefix form one character per item, the final one
// marked by last_out, with the status (ok, unbalanced parenthesis, input too
// long) on every item. Up to 64 characters are kept; further ones are dropped
// and flagged. Loading takes one cycle per item. After the final item the
// block stops taking input while it converts: each stored character is read,
// dispatched and, for an operator, pops the stack by priority; the stack is
// then flushed into the answer, which is read back item by item, each read
// waiting for the output handshake. The single sequencer steps through the
// input, stack and answer memories, whose reads are registered. An empty
// answer gives one item with has_char 0.
module infix_to_prefix_converter_unit
	import ipc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	ipc_in_if.sink    in_ch,
	ipc_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	ipc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_in),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and payload
	ipc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_char  (in_ch.in_char),
		.out_char (out_ch.out_char),
		.has_char (out_ch.has_char),
		.last_out (out_ch.last_out),
		.status   (out_ch.status)
	);

endmodule
